// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the two-key combo detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/core/tkc_pkg.sv =====
package tkc_pkg;

	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned ShortCntW = 8;
	localparam int unsigned ComboCntW = 16;

	localparam logic [CfgIdxW-1:0] REG_DEBOUNCE     = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_SHORT_WINDOW = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_LONG_DELAY   = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_COMBO_HOLD   = 2'd3;

	localparam logic [ShortCntW-1:0] DEBOUNCE_RST     = 8'd3;
	localparam logic [ShortCntW-1:0] SHORT_WINDOW_RST = 8'd100;
	localparam logic [ShortCntW-1:0] LONG_DELAY_RST   = 8'd3;
	localparam logic [ComboCntW-1:0] COMBO_HOLD_RST   = 16'd500;

	typedef struct packed {
		logic [ShortCntW-1:0] debounce_ticks;
		logic [ShortCntW-1:0] short_window_ticks;
		logic [ShortCntW-1:0] long_delay_ticks;
		logic [ComboCntW-1:0] combo_hold_ticks;
	} cfg_t;

	typedef enum logic [2:0] {
		EV_NONE        = 3'd0,
		EV_COMBO       = 3'd1,
		EV_PLUS_SHORT  = 3'd2,
		EV_PLUS_LONG   = 3'd3,
		EV_MINUS_SHORT = 3'd4,
		EV_MINUS_LONG  = 3'd5
	} key_event_t;

	typedef enum logic [6:0] {
		PH_IDLE    = 7'b0000001,
		PH_P_QUAL  = 7'b0000010,
		PH_P_DELAY = 7'b0000100,
		PH_P_LONG  = 7'b0001000,
		PH_M_QUAL  = 7'b0010000,
		PH_M_DELAY = 7'b0100000,
		PH_M_LONG  = 7'b1000000
	} phase_t;

endpackage

// ===== rtl/core/two_key_combo_short_long_press.sv =====
// Two-key combo / short / long press detector, plus key and minus key.
// Input channel: one request per scan tick (plus_pressed, minus_pressed),
// handshake in_valid / in_stall. Output channel: exactly one key_event per
// request (0 none, 1 combo, 2 plus short, 3 plus long, 4 minus short,
// 5 minus long), handshake out_valid / out_stall, in request order.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 debounce, 1 short window, 2 long delay, 3 combo hold); write only idle.
// The event of a request is computed from the input register and registered
// in the event register when the output advances, which raises out_valid.
// Throughput: one request per cycle unless out_stall holds an event; the key
// state machine updates in one pass between the input and event registers.
// Reset: clears the key state, both pipeline valids and loads the default
// thresholds (3, 100, 3, 500).
// Stall: while out_stall holds a pending event, the input register holds
// its request and in_stall is raised; nothing is dropped or repeated.
`include "assert_macros.svh"

module two_key_combo_short_long_press (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tkc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [tkc_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          plus_pressed,
	input  logic                          minus_pressed,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    key_event
);
	import tkc_pkg::*;

	cfg_t       cfg;
	logic       valid_s1, plus_s1, minus_s1;
	logic       valid_q;
	logic [2:0] key_event_q;
	logic       advance;
	key_event_t ev;

	assign advance  = !valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	tkc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tkc_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.step       (valid_s1 && advance),
		.plus_held  (plus_s1),
		.minus_held (minus_s1),
		.ev         (ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (advance)
				valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			plus_s1  <= plus_pressed;
			minus_s1 <= minus_pressed;
		end
		if (advance && valid_s1)
			key_event_q <= ev;
	end

	assign out_valid = valid_q;
	assign key_event = key_event_q;

	`ASSERT_IMPLY(a_stall_needs_full, clk, arst_n, in_stall, valid_q && out_stall)

endmodule

// ===== rtl/core/tkc_cfg.sv =====
module tkc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tkc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [tkc_pkg::CfgDataW-1:0]  cfg_data,
	output tkc_pkg::cfg_t                 cfg
);
	import tkc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks     <= DEBOUNCE_RST;
			cfg_q.short_window_ticks <= SHORT_WINDOW_RST;
			cfg_q.long_delay_ticks   <= LONG_DELAY_RST;
			cfg_q.combo_hold_ticks   <= COMBO_HOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEBOUNCE:     cfg_q.debounce_ticks     <= cfg_data[ShortCntW-1:0];
				REG_SHORT_WINDOW: cfg_q.short_window_ticks <= cfg_data[ShortCntW-1:0];
				REG_LONG_DELAY:   cfg_q.long_delay_ticks   <= cfg_data[ShortCntW-1:0];
				REG_COMBO_HOLD:   cfg_q.combo_hold_ticks   <= cfg_data[ComboCntW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/tkc_fsm.sv =====
`include "assert_macros.svh"

module tkc_fsm (
	input  logic                clk,
	input  logic                arst_n,
	input  tkc_pkg::cfg_t       cfg,
	input  logic                step,
	input  logic                plus_held,
	input  logic                minus_held,
	output tkc_pkg::key_event_t ev
);
	import tkc_pkg::*;

	logic                 latched_q, latched_d;
	logic [ComboCntW-1:0] combo_cnt_q, combo_cnt_d, combo_inc;
	logic [ShortCntW-1:0] single_cnt_q, single_cnt_d, single_inc;
	phase_t               phase_q, phase_d;
	key_event_t           ev_d;

	assign combo_inc  = combo_cnt_q + ComboCntW'(1);
	assign single_inc = single_cnt_q + ShortCntW'(1);

	always_comb begin
		latched_d    = latched_q;
		combo_cnt_d  = combo_cnt_q;
		single_cnt_d = single_cnt_q;
		phase_d      = phase_q;
		ev_d         = EV_NONE;
		if (latched_q) begin
			if (!plus_held || !minus_held) begin
				latched_d    = 1'b0;
				combo_cnt_d  = '0;
				single_cnt_d = '0;
			end
		end else if (plus_held && minus_held) begin
			phase_d      = PH_IDLE;
			single_cnt_d = '0;
			if (combo_inc >= cfg.combo_hold_ticks) begin
				combo_cnt_d = '0;
				latched_d   = 1'b1;
				ev_d        = EV_COMBO;
			end else begin
				combo_cnt_d = combo_inc;
			end
		end else begin
			combo_cnt_d = '0;
			unique case (phase_q)
				PH_IDLE: begin
					single_cnt_d = single_inc;
					if (plus_held || minus_held) begin
						if (single_inc >= cfg.debounce_ticks) begin
							single_cnt_d = '0;
							phase_d      = plus_held ? PH_P_QUAL : PH_M_QUAL;
						end
					end else begin
						single_cnt_d = '0;
					end
				end
				PH_P_QUAL, PH_M_QUAL: begin
					if (!(phase_q == PH_P_QUAL ? plus_held : minus_held)) begin
						// count deliberately kept on short release
						phase_d = PH_IDLE;
						ev_d    = (phase_q == PH_P_QUAL) ? EV_PLUS_SHORT : EV_MINUS_SHORT;
					end else begin
						single_cnt_d = single_inc;
						if (single_inc >= cfg.short_window_ticks) begin
							single_cnt_d = '0;
							phase_d      = (phase_q == PH_P_QUAL) ? PH_P_DELAY : PH_M_DELAY;
						end
					end
				end
				PH_P_DELAY, PH_M_DELAY: begin
					single_cnt_d = single_inc;
					if (single_inc >= cfg.long_delay_ticks) begin
						single_cnt_d = '0;
						phase_d      = (phase_q == PH_P_DELAY) ? PH_P_LONG : PH_M_LONG;
					end
					if (!(phase_q == PH_P_DELAY ? plus_held : minus_held))
						phase_d = PH_IDLE;
				end
				PH_P_LONG, PH_M_LONG: begin
					if (!(phase_q == PH_P_LONG ? plus_held : minus_held))
						phase_d = PH_IDLE;
					ev_d = (phase_q == PH_P_LONG) ? EV_PLUS_LONG : EV_MINUS_LONG;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_q    <= 1'b0;
			combo_cnt_q  <= '0;
			single_cnt_q <= '0;
			phase_q      <= PH_IDLE;
		end else if (step) begin
			latched_q    <= latched_d;
			combo_cnt_q  <= combo_cnt_d;
			single_cnt_q <= single_cnt_d;
			phase_q      <= phase_d;
		end
	end

	assign ev = ev_d;

	`ASSERT_IMPLY(a_latched_idle, clk, arst_n, latched_q, phase_q == PH_IDLE)
	`ASSERT_IMPLY(a_latched_cnt_clear, clk, arst_n, latched_q, combo_cnt_q == '0)
	`ASSERT_NEXT(a_combo_latches, clk, arst_n, step && ev_d == EV_COMBO, latched_q)

endmodule
